[src/iqlm_pkg.sv]
// Shared types and constants for the IQ level monitor.
package iqlm_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE       = 3'd0,
        REG_REAL_UPPER   = 3'd1,
        REG_REAL_LOWER   = 3'd2,
        REG_IMAG_UPPER   = 3'd3,
        REG_IMAG_LOWER   = 3'd4,
        REG_WINDOW_LOG2  = 3'd5
    } cfg_reg_t;

    // Window length register, in log2 samples.
    localparam int                    WIN_CFG_W       = 5;
    localparam logic [WIN_CFG_W-1:0]  WIN_LOG2_RESET  = 5'd20;
    localparam int                    MIN_WINDOW_LOG2 = 4;

    // Threshold counters.
    localparam int COUNT_W        = 32;
    localparam int NUM_COUNTS     = 4;
    localparam int CNT_REAL_OVER  = 0;
    localparam int CNT_REAL_UNDER = 1;
    localparam int CNT_IMAG_OVER  = 2;
    localparam int CNT_IMAG_UNDER = 3;

endpackage

[src/iq_level_monitor_core.sv]
// IQ level monitor: peaks, threshold counts and window means of a complex stream.
// An accepted sample is held in the input register, then, while enabled, folded into
// the statistics; a window report is registered in the output register until taken.
// Throughput: one sample per cycle; the only stall is a report waiting on a full output.
// Reset: rst_n clears all statistics, the window count and both valid flags at once,
// and loads the register defaults (enabled, thresholds +-1.0, window of 2^20 samples).
module iq_level_monitor_core
    import iqlm_pkg::*;
#(
    parameter int MAX_WINDOW_LOG2 = 24,
    parameter int SAMPLE_WIDTH    = 16
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    // Sample input.
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // s_tdata, low bit up: sample_real, sample_imag, zero padding.
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         s_tdata,
    // Report output.
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // m_tdata, low bit up: real_peak_high, real_peak_low, imag_peak_high,
    // imag_peak_low, real_over_count, real_under_count, imag_over_count,
    // imag_under_count, real_window_mean, imag_window_mean, zero padding.
    output logic [((6*SAMPLE_WIDTH-2+4*32+7)/8)*8-1:0]  m_tdata,
    // Configuration write channel.
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [CFG_INDEX_W-1:0]                      cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]                     cfg_data
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = MAX_WINDOW_LOG2;
    localparam int KW     = $clog2(MAX_WINDOW_LOG2 + 1);
    localparam int SUM_W  = SAMPLE_WIDTH + MAX_WINDOW_LOG2;
    localparam int OUT_W  = 6*SAMPLE_WIDTH - 2 + NUM_COUNTS*COUNT_W;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    localparam logic signed [SW-1:0] THRESH_ONE = SW'(1) << (SW - 3);
    localparam logic [5:0]           K_MIN      = 6'(MIN_WINDOW_LOG2);
    localparam logic [5:0]           K_MAX      = 6'(MAX_WINDOW_LOG2);

    // Configuration registers.
    logic                   enable_reg;
    logic signed [SW-1:0]   real_upper_reg;
    logic signed [SW-1:0]   real_lower_reg;
    logic signed [SW-1:0]   imag_upper_reg;
    logic signed [SW-1:0]   imag_lower_reg;
    logic [WIN_CFG_W-1:0]   win_log2_reg;

    // Input register.
    logic                   s1_valid_reg;
    logic signed [SW-1:0]   s1_real_reg;
    logic signed [SW-1:0]   s1_imag_reg;

    // Statistics.
    logic signed [SW-1:0]    real_max_reg, real_max_next;
    logic signed [SW-1:0]    real_min_reg, real_min_next;
    logic signed [SW-1:0]    imag_max_reg, imag_max_next;
    logic signed [SW-1:0]    imag_min_reg, imag_min_next;
    logic [COUNT_W-1:0]      exc_cnt_reg  [NUM_COUNTS];
    logic [COUNT_W-1:0]      exc_cnt_next [NUM_COUNTS];
    logic [NUM_COUNTS-1:0]   exc_hit;
    logic signed [SUM_W-1:0] real_sum_reg, real_sum_next;
    logic signed [SUM_W-1:0] imag_sum_reg, imag_sum_next;
    logic [CW-1:0]           win_cnt_reg, win_cnt_next;

    // Output register.
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic [OUT_W-1:0]       out_data_next;

    logic [5:0]             k_wide;
    logic [KW-1:0]          k_eff;
    logic                   window_done;
    logic                   out_free;
    logic                   advance;
    logic                   step;
    logic                   report;
    logic signed [SW-1:0]   real_avg;
    logic signed [SW-1:0]   imag_avg;

    // Floor of sum / 2^k, saturated to the sample range.
    function automatic logic signed [SW-1:0] mean_sat(
        input logic signed [SUM_W-1:0] sum,
        input logic [KW-1:0]           k
    );
        logic signed [SUM_W-1:0] shifted;
        logic [SUM_W-SW:0]       top;
        shifted = sum >>> k;
        top     = shifted[SUM_W-1:SW-1];
        if ((&top) || !(|top))
        begin
            return shifted[SW-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            return {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(SW-1){1'b1}}};
        end
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            real_upper_reg <= THRESH_ONE;
            real_lower_reg <= -THRESH_ONE;
            imag_upper_reg <= THRESH_ONE;
            imag_lower_reg <= -THRESH_ONE;
            win_log2_reg   <= WIN_LOG2_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ENABLE:      enable_reg     <= cfg_data[0];
                REG_REAL_UPPER:  real_upper_reg <= $signed(cfg_data);
                REG_REAL_LOWER:  real_lower_reg <= $signed(cfg_data);
                REG_IMAG_UPPER:  imag_upper_reg <= $signed(cfg_data);
                REG_IMAG_LOWER:  imag_lower_reg <= $signed(cfg_data);
                REG_WINDOW_LOG2: win_log2_reg   <= cfg_data[WIN_CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // Window length, clamped to the supported range.
    always_comb
    begin
        k_wide = {1'b0, win_log2_reg};
        if (k_wide < K_MIN)
        begin
            k_wide = K_MIN;
        end
        else if (k_wide > K_MAX)
        begin
            k_wide = K_MAX;
        end
        k_eff = k_wide[KW-1:0];
    end

    // The window also closes when the counter wraps at the longest window.
    assign win_cnt_next = win_cnt_reg + CW'(1);
    assign window_done  = (win_cnt_next == '0) || ((win_cnt_next >> k_eff) != '0);

    // A sample held in the input register moves on unless it would close a window
    // while the previous report still sits in the output register.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = s1_valid_reg && (!enable_reg || !window_done || out_free);
    assign step     = advance && enable_reg;
    assign report   = step && window_done;
    assign s_tready = !s1_valid_reg || advance;

    always_comb
    begin
        real_max_next = (s1_real_reg > real_max_reg) ? s1_real_reg : real_max_reg;
        real_min_next = (s1_real_reg < real_min_reg) ? s1_real_reg : real_min_reg;
        imag_max_next = (s1_imag_reg > imag_max_reg) ? s1_imag_reg : imag_max_reg;
        imag_min_next = (s1_imag_reg < imag_min_reg) ? s1_imag_reg : imag_min_reg;

        exc_hit[CNT_REAL_OVER]  = s1_real_reg > real_upper_reg;
        exc_hit[CNT_REAL_UNDER] = s1_real_reg < real_lower_reg;
        exc_hit[CNT_IMAG_OVER]  = s1_imag_reg > imag_upper_reg;
        exc_hit[CNT_IMAG_UNDER] = s1_imag_reg < imag_lower_reg;

        for (int i = 0; i < NUM_COUNTS; i++)
        begin
            exc_cnt_next[i] = exc_cnt_reg[i];
            if (exc_hit[i] && !(&exc_cnt_reg[i]))
            begin
                exc_cnt_next[i] = exc_cnt_reg[i] + COUNT_W'(1);
            end
        end

        real_sum_next = real_sum_reg + SUM_W'(s1_real_reg);
        imag_sum_next = imag_sum_reg + SUM_W'(s1_imag_reg);

        real_avg = mean_sat(real_sum_next, k_eff);
        imag_avg = mean_sat(imag_sum_next, k_eff);

        out_data_next = {imag_avg, real_avg,
                         exc_cnt_next[CNT_IMAG_UNDER], exc_cnt_next[CNT_IMAG_OVER],
                         exc_cnt_next[CNT_REAL_UNDER], exc_cnt_next[CNT_REAL_OVER],
                         imag_min_next, imag_max_next[SW-2:0],
                         real_min_next, real_max_next[SW-2:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_real_reg <= $signed(s_tdata[SW-1:0]);
            s1_imag_reg <= $signed(s_tdata[2*SW-1:SW]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_max_reg <= '0;
            real_min_reg <= '0;
            imag_max_reg <= '0;
            imag_min_reg <= '0;
            real_sum_reg <= '0;
            imag_sum_reg <= '0;
            win_cnt_reg  <= '0;
            for (int i = 0; i < NUM_COUNTS; i++)
            begin
                exc_cnt_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            real_max_reg <= real_max_next;
            real_min_reg <= real_min_next;
            imag_max_reg <= imag_max_next;
            imag_min_reg <= imag_min_next;
            for (int i = 0; i < NUM_COUNTS; i++)
            begin
                exc_cnt_reg[i] <= exc_cnt_next[i];
            end
            if (window_done)
            begin
                real_sum_reg <= '0;
                imag_sum_reg <= '0;
                win_cnt_reg  <= '0;
            end
            else
            begin
                real_sum_reg <= real_sum_next;
                imag_sum_reg <= imag_sum_next;
                win_cnt_reg  <= win_cnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (report)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (report)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'(out_data_reg);

    // A report never overwrites a word that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        report |-> (!out_valid_reg || m_tready))
        else $error("report would overwrite a pending output word");

    // Closing a window always restarts the window count.
    assert property (@(posedge clk) disable iff (!rst_n)
        report |=> (win_cnt_reg == '0) && (real_sum_reg == '0) && (imag_sum_reg == '0))
        else $error("window state not cleared after report");

    // Peaks start at zero, so the maximum stays non-negative and the minimum non-positive.
    assert property (@(posedge clk) disable iff (!rst_n)
        !real_max_reg[SW-1] && !imag_max_reg[SW-1] &&
        (real_min_reg[SW-1] || (real_min_reg == '0)) &&
        (imag_min_reg[SW-1] || (imag_min_reg == '0)))
        else $error("peak register crossed zero");

    // A full real-over count stays full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (&exc_cnt_reg[CNT_REAL_OVER]) |=> (&exc_cnt_reg[CNT_REAL_OVER]))
        else $error("saturated count wrapped");

    // A held sample is neither lost nor changed while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=>
            (s1_valid_reg && $stable(s1_real_reg) && $stable(s1_imag_reg)))
        else $error("stalled sample lost");

endmodule
